FILE: rtl/gtl_pkg.sv
// Shared types, character codes and the transliteration table of the transliterator.
package gtl_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned MAX_RUN  = 4;
  localparam int unsigned RUN_CNT_W = 3;
  localparam int unsigned RUN_IDX_W = 2;

  // Greek codes that take part in the digraph rules.
  localparam logic [CHAR_W-1:0] CODE_MU_UP  = 8'd204;
  localparam logic [CHAR_W-1:0] CODE_MU_LO  = 8'd236;
  localparam logic [CHAR_W-1:0] CODE_NU_UP  = 8'd205;
  localparam logic [CHAR_W-1:0] CODE_NU_LO  = 8'd237;
  localparam logic [CHAR_W-1:0] CODE_PI_UP  = 8'd208;
  localparam logic [CHAR_W-1:0] CODE_PI_LO  = 8'd240;
  localparam logic [CHAR_W-1:0] CODE_TAU_UP = 8'd212;
  localparam logic [CHAR_W-1:0] CODE_TAU_LO = 8'd244;

  localparam logic [CHAR_W-1:0] CH_APOS  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    PEND_NONE   = 3'd0,
    PEND_MU_UP  = 3'd1,
    PEND_MU_LO  = 3'd2,
    PEND_NU_UP  = 3'd3,
    PEND_NU_LO  = 3'd4
  } pend_t;

  // A length of zero means the code has no entry and passes through unchanged.
  typedef struct packed {
    logic [1:0]        len;
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
    logic [CHAR_W-1:0] c2;
  } xlat_entry_t;

  typedef struct packed {
    logic              eos;
    logic [CHAR_W-1:0] code;
    xlat_entry_t       entry;
  } gtl_item_t;

  function automatic xlat_entry_t mk1(input logic [CHAR_W-1:0] a);
    xlat_entry_t e;
    e = '{len: 2'd1, c0: a, c1: CH_NUL, c2: CH_NUL};
    return e;
  endfunction

  function automatic xlat_entry_t mk2(input logic [CHAR_W-1:0] a,
                                      input logic [CHAR_W-1:0] b);
    xlat_entry_t e;
    e = '{len: 2'd2, c0: a, c1: b, c2: CH_NUL};
    return e;
  endfunction

  function automatic xlat_entry_t mk3(input logic [CHAR_W-1:0] a,
                                      input logic [CHAR_W-1:0] b,
                                      input logic [CHAR_W-1:0] c);
    xlat_entry_t e;
    e = '{len: 2'd3, c0: a, c1: b, c2: c};
    return e;
  endfunction

  function automatic xlat_entry_t xlat_lookup(input logic [CHAR_W-1:0] code);
    xlat_entry_t e;
    e = '{len: 2'd0, c0: CH_NUL, c1: CH_NUL, c2: CH_NUL};
    case (code)
      8'd180: e = mk1(CH_APOS);
      8'd181: e = mk2(CH_APOS, CH_QUOTE);
      8'd182: e = mk2(CH_APOS, "A");
      8'd184: e = mk2(CH_APOS, "E");
      8'd185: e = mk2(CH_APOS, "H");
      8'd186: e = mk2(CH_APOS, "I");
      8'd188: e = mk2(CH_APOS, "O");
      8'd190: e = mk2(CH_APOS, "Y");
      8'd191: e = mk2(CH_APOS, "W");
      8'd192: e = mk3("i", CH_APOS, CH_QUOTE);
      8'd193: e = mk1("A");
      8'd194: e = mk1("V");
      8'd195: e = mk1("G");
      8'd196: e = mk1("D");
      8'd197: e = mk1("E");
      8'd198: e = mk1("Z");
      8'd199: e = mk1("H");
      8'd200: e = mk1("8");
      8'd201: e = mk1("I");
      8'd202: e = mk1("K");
      8'd203: e = mk1("L");
      8'd204: e = mk1("M");
      8'd205: e = mk1("N");
      8'd206: e = mk2("K", "S");
      8'd207: e = mk1("O");
      8'd208: e = mk1("P");
      8'd209: e = mk1("R");
      8'd211: e = mk1("S");
      8'd212: e = mk1("T");
      8'd213: e = mk1("Y");
      8'd214: e = mk1("F");
      8'd215: e = mk1("X");
      8'd216: e = mk2("P", "S");
      8'd217: e = mk1("W");
      8'd218: e = mk2("I", CH_QUOTE);
      8'd219: e = mk2("Y", CH_QUOTE);
      8'd220: e = mk2("a", CH_APOS);
      8'd221: e = mk2("e", CH_APOS);
      8'd222: e = mk2("h", CH_APOS);
      8'd223: e = mk2("i", CH_APOS);
      8'd224: e = mk3("y", CH_APOS, CH_QUOTE);
      8'd225: e = mk1("a");
      8'd226: e = mk1("v");
      8'd227: e = mk1("g");
      8'd228: e = mk1("d");
      8'd229: e = mk1("e");
      8'd230: e = mk1("z");
      8'd231: e = mk1("h");
      8'd232: e = mk1("8");
      8'd233: e = mk1("i");
      8'd234: e = mk1("k");
      8'd235: e = mk1("l");
      8'd236: e = mk1("m");
      8'd237: e = mk1("n");
      8'd238: e = mk2("k", "s");
      8'd239: e = mk1("o");
      8'd240: e = mk1("p");
      8'd241: e = mk1("r");
      8'd242: e = mk1("s");
      8'd243: e = mk1("s");
      8'd244: e = mk1("t");
      8'd245: e = mk1("y");
      8'd246: e = mk1("f");
      8'd247: e = mk1("x");
      8'd248: e = mk2("p", "s");
      8'd249: e = mk1("w");
      8'd250: e = mk2("i", CH_QUOTE);
      8'd251: e = mk2("y", CH_QUOTE);
      8'd252: e = mk2("o", CH_APOS);
      8'd253: e = mk2("y", CH_APOS);
      8'd254: e = mk2("w", CH_APOS);
      default: e = '{len: 2'd0, c0: CH_NUL, c1: CH_NUL, c2: CH_NUL};
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/gtl_xlat_rom.sv
// Synchronous-read table memory holding the Latin spelling of each ISO-8859-7 code.
module gtl_xlat_rom
  import gtl_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [CHAR_W-1:0] rd_addr,
  output xlat_entry_t       rd_data
);

  xlat_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= xlat_lookup(rd_addr);
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/gtl_expand.sv
// Digraph resolution, pending letter and run buffer; one character a cycle while not stalled.
module gtl_expand
  import gtl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  gtl_item_t         item,
  output logic              item_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last_of_run
);

  pend_t                pend_r, pend_nxt, pend_new;
  logic [CHAR_W-1:0]    run_r [MAX_RUN];
  logic [RUN_CNT_W-1:0] cnt_r;
  logic [RUN_IDX_W-1:0] idx_r;
  logic                 busy_r;

  logic [CHAR_W-1:0]    seq [MAX_RUN];
  logic [RUN_CNT_W-1:0] seq_n;
  logic                 is_mu, is_nu;
  logic [CHAR_W-1:0]    held;
  logic                 last;
  logic                 out_fire;
  logic                 buf_free;

  always_comb begin
    held  = CH_NUL;
    is_mu = 1'b0;
    is_nu = 1'b0;
    unique case (pend_r)
      PEND_MU_UP: begin held = "M"; is_mu = 1'b1; end
      PEND_MU_LO: begin held = "m"; is_mu = 1'b1; end
      PEND_NU_UP: begin held = "N"; is_nu = 1'b1; end
      PEND_NU_LO: begin held = "n"; is_nu = 1'b1; end
      default:    begin held = CH_NUL; end
    endcase
  end

  // Build the whole run of characters for the waiting item.
  always_comb begin
    for (int i = 0; i < MAX_RUN; i++) begin
      seq[i] = CH_NUL;
    end
    seq_n    = '0;
    pend_new = PEND_NONE;
    if (item.eos) begin
      if (is_mu || is_nu) begin
        seq[0] = held;
        seq_n  = 3'd1;
      end
    end else if (is_mu && (item.code == CODE_PI_UP || item.code == CODE_PI_LO)) begin
      seq[0] = (pend_r == PEND_MU_UP) ? "B" : "b";
      seq_n  = 3'd1;
    end else if (is_nu && (item.code == CODE_TAU_UP || item.code == CODE_TAU_LO)) begin
      seq[0] = (pend_r == PEND_NU_UP) ? "D" : "d";
      seq_n  = 3'd1;
    end else if (is_mu || is_nu) begin
      seq[0] = held;
      if (item.entry.len == 2'd0) begin
        seq[1] = item.code;
        seq_n  = 3'd2;
      end else begin
        seq[1] = item.entry.c0;
        seq[2] = item.entry.c1;
        seq[3] = item.entry.c2;
        seq_n  = 3'd1 + {1'b0, item.entry.len};
      end
    end else if (item.code == CODE_MU_UP) begin
      pend_new = PEND_MU_UP;
    end else if (item.code == CODE_MU_LO) begin
      pend_new = PEND_MU_LO;
    end else if (item.code == CODE_NU_UP) begin
      pend_new = PEND_NU_UP;
    end else if (item.code == CODE_NU_LO) begin
      pend_new = PEND_NU_LO;
    end else if (item.entry.len == 2'd0) begin
      seq[0] = item.code;
      seq_n  = 3'd1;
    end else begin
      seq[0] = item.entry.c0;
      seq[1] = item.entry.c1;
      seq[2] = item.entry.c2;
      seq_n  = {1'b0, item.entry.len};
    end
  end

  assign last      = ({1'b0, idx_r} == (cnt_r - 3'd1));
  assign out_valid = busy_r;
  assign out_fire  = busy_r && !out_stall;
  assign out_char  = run_r[idx_r];
  assign out_last_of_run = last;
  assign buf_free  = !busy_r || (out_fire && last);

  // Items that produce nothing only update the pending letter, so they never wait.
  assign item_take = item_valid && ((seq_n == '0) || buf_free);
  assign pend_nxt  = item_take ? pend_new : pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      busy_r <= 1'b0;
      idx_r  <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (item_take && (seq_n != '0)) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        cnt_r  <= seq_n;
      end else if (out_fire) begin
        if (last) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && (seq_n != '0)) begin
      for (int i = 0; i < MAX_RUN; i++) begin
        run_r[i] <= seq[i];
      end
    end
  end

endmodule

FILE: rtl/greek_to_latin_transliterator_top.sv
// Top level of the ISO-8859-7 to Greeklish transliterator.
// Each request carries one ISO-8859-7 byte or an end-of-stream mark and yields zero to four
// ASCII characters, one per cycle on the output channel unless out_stall holds it, the last
// flagged by out_last_of_run. A request is registered in the input stage while the table
// memory is read, then its whole run is loaded into the output buffer once the buffer is
// free; the buffer sends one character a cycle unless out_stall holds it, and a request
// with none (a held mu or nu, or an end mark with nothing held) passes without waiting for
// the buffer. A new request is taken into the input stage while the current run drains.
module greek_to_latin_transliterator_top
  import gtl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_byte,
  input  logic              in_end_of_stream,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last_of_run
);

  logic              stg_valid_r;
  logic              stg_eos_r;
  logic [CHAR_W-1:0] stg_code_r;
  logic              in_fire;
  logic              take;
  xlat_entry_t       entry;
  gtl_item_t         item;

  assign in_stall = stg_valid_r && !take;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_fire) begin
      stg_valid_r <= 1'b1;
    end else if (take) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_eos_r  <= in_end_of_stream;
      stg_code_r <= in_byte;
    end
  end

  gtl_xlat_rom u_rom (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_byte),
    .rd_data (entry)
  );

  assign item = '{eos: stg_eos_r, code: stg_code_r, entry: entry};

  gtl_expand u_expand (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (stg_valid_r),
    .item            (item),
    .item_take       (take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule
